### hw/rtl/bitmap_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Concurrent check helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsa: same-cycle check failed");

// next-cycle implication
`define BSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsa: next-cycle check failed");

`endif

### hw/rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Command and status codes, field widths and register reset value.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int IDX_W     = 12;
   localparam int CSR_W     = 7;

   typedef logic [IDX_W-1:0] slot_idx_type;
   typedef logic [1:0]       status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_WORDS_RESET = 7'd64;

endpackage

### hw/rtl/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Find-first-zero allocator over a bitmap of 64-bit words held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a command transfers when start is high and busy is low.
//   req_cmd selects allocate or free; req_free_index names the slot to free.
//   Result channel: rsp_valid strobes for one cycle with rsp_slot_index and
//   rsp_status; the receiver cannot stall, so a result is never held.
//   Configuration: csr_wdata (words in use) transfers on csr_valid and
//   csr_ready; csr_ready is high while the block is not busy and no command
//   is starting.
//   Allocate: the transfer reads word 0 of the bitmap RAM; in the scan state
//   each registered word is checked while the next one is read. The first
//   word with a zero bit grants its lowest zero bit; if every word in use is
//   full it answers full. Busy drops in the same cycle as the strobe. The scan
//   reads one word per cycle from the bitmap RAM and takes no new command
//   until it answers. An in-range free reads its word, then writes it back.
//   An out-of-range free or a zero-word allocate answers in the next cycle.
//   Reset clears the per-word valid flags, so the whole bitmap reads as free
//   at once, and sets words in use to 64.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int BITMAP_WORDS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [IDX_W-1:0]   req_free_index,
   output logic               rsp_valid,
   output logic [IDX_W-1:0]   rsp_slot_index,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int MemWords = (BITMAP_WORDS < WORD_BITS) ? BITMAP_WORDS : WORD_BITS;
   localparam int AW       = (MemWords > 1) ? $clog2(MemWords) : 1;
   localparam logic [CSR_W-1:0] MemWordsN = CSR_W'(MemWords);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FREE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic [AW-1:0]        word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_slot_ff, rsp_slot_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CSR_W-1:0]     csr_words_ff, csr_words_in;
   logic [MemWords-1:0]  valid_ff;

   logic [WORD_BITS-1:0] mem_q [MemWords];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] word_q;
   logic [BIT_W-1:0]     zbit;
   logic [CSR_W-1:0]     eff_words;
   logic [AW-1:0]        free_word;
   logic                 free_ok;

   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            pos = BIT_W'(b);
         end
      end
      return pos;
   endfunction

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = !busy && !start;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

   assign eff_words = (csr_words_ff > MemWordsN) ? MemWordsN : csr_words_ff;
   assign free_word = AW'(req_free_index[IDX_W-1:BIT_W]);
   assign free_ok   = ({1'b0, req_free_index} < {eff_words, {BIT_W{1'b0}}});
   assign word_q    = rd_vld_ff ? rd_data_ff : '0;
   assign zbit      = lowest_zero(word_q);
   assign csr_words_in = (csr_valid && csr_ready) ? csr_wdata : csr_words_ff;

   always_comb begin
      state_in      = state_ff;
      chk_in        = chk_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = chk_ff;
      wr_data       = word_q;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = (req_cmd == CMD_FREE) ? free_word : '0;
            if (start) begin
               if (req_cmd == CMD_ALLOC) begin
                  if (eff_words == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = '0;
                     rsp_status_in = ST_FULL;
                  end else begin
                     chk_in   = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  idx_in  = req_free_index;
                  word_in = free_word;
                  bit_in  = req_free_index[BIT_W-1:0];
                  if (free_ok) begin
                     state_in = S_FREE;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = req_free_index;
                     rsp_status_in = ST_RANGE;
                  end
               end
            end
         end
         S_SCAN: begin
            rd_addr = chk_ff + AW'(1);
            if (!(&word_q)) begin
               wr_en         = 1'b1;
               wr_addr       = chk_ff;
               wr_data       = word_q | (WORD_BITS'(1) << zbit);
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = {BIT_W'(chk_ff), zbit};
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else if ((CSR_W'(chk_ff) + CSR_W'(1)) == eff_words) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               chk_in = chk_ff + AW'(1);
            end
         end
         S_FREE: begin
            wr_en         = 1'b1;
            wr_addr       = word_ff;
            wr_data       = word_q & ~(WORD_BITS'(1) << bit_ff);
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = idx_ff;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         csr_words_ff <= CSR_WORDS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_words_ff <= csr_words_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      idx_ff        <= idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_q[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   `BSA_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid_ff, !busy)
   `BSA_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == S_SCAN,
      (CSR_W'(chk_ff) < eff_words))
   `BSA_ASSERT_NXT(a_free_range_flag, clock, reset,
      start && !busy && (req_cmd == CMD_FREE) && !free_ok,
      rsp_valid_ff && (rsp_status_ff == ST_RANGE))
   `BSA_ASSERT_IMP(a_full_slot_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_FULL), rsp_slot_ff == '0)

endmodule

### dv/slot_grant_checker.sv
// ----------------------------------------------------------------------------
// Slot grant checker
// Watches the command, result and register channels of the allocator, keeps
// its own copy of the bitmap and the word count, predicts the grant or
// release status of every accepted command and compares each result strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module slot_grant_checker
   import bsa_pkg::*;
#(
   parameter int BITMAP_WORDS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_cmd,
   input  slot_idx_type       req_free_index,
   input  logic               rsp_valid,
   input  slot_idx_type       rsp_slot_index,
   input  status_type         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      slot_idx_type slot;
      status_type   status;
   } grant_type;

   logic [WORD_BITS-1:0] slot_map [BITMAP_WORDS];
   logic [CSR_W-1:0]     words_cfg;
   grant_type            grant_q [$];
   int                   fails = 0;

   function automatic int active_words();
      int n;
      n = int'(words_cfg);
      if (n > BITMAP_WORDS) n = BITMAP_WORDS;
      if (n > WORD_BITS) n = WORD_BITS;
      return n;
   endfunction

   function automatic grant_type predict_grant(input logic cmd, input slot_idx_type idx);
      grant_type g;
      int        n;
      int        w;
      int        b;
      bit        found;
      n        = active_words();
      g.slot   = '0;
      g.status = ST_FULL;
      found    = 1'b0;
      if (cmd == CMD_ALLOC) begin
         for (w = 0; w < n && !found; w++) begin
            if (~slot_map[w] != '0) begin
               for (b = 0; b < WORD_BITS && !found; b++) begin
                  if (!slot_map[w][b]) begin
                     slot_map[w][b] = 1'b1;
                     g.slot   = slot_idx_type'(w * WORD_BITS + b);
                     g.status = ST_OK;
                     found    = 1'b1;
                  end
               end
            end
         end
      end else begin
         g.slot = idx;
         if (int'(idx) >= n * WORD_BITS) begin
            g.status = ST_RANGE;
         end else begin
            slot_map[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = 1'b0;
            g.status = ST_OK;
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin : monitor
      grant_type exp_g;
      if (reset) begin
         for (int i = 0; i < BITMAP_WORDS; i++) slot_map[i] = '0;
         words_cfg = CSR_WORDS_RESET;
         grant_q.delete();
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (grant_q.size() == 0) begin
               $display("%0t: result with nothing outstanding: slot %0d status %0d",
                        $time, rsp_slot_index, rsp_status);
               fails++;
            end else begin
               exp_g = grant_q.pop_front();
               if (rsp_slot_index !== exp_g.slot) begin
                  $display("%0t: slot_index mismatch: expected %0d actual %0d",
                           $time, exp_g.slot, rsp_slot_index);
                  fails++;
               end
               if (rsp_status !== exp_g.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, exp_g.status, rsp_status);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) words_cfg = csr_wdata;
         if (start && !busy) grant_q.push_back(predict_grant(req_cmd, req_free_index));
         pending <= grant_q.size();
      end
      fail_count <= fails;
   end

endmodule

### dv/tb_bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives allocate and free commands through directed cases and random phases
// over many word-count settings, with random gaps before the first 1200
// commands, and leaves prediction and comparison to the slot grant checker.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator
   import bsa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASES       = 17;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 70;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_cmd;
   slot_idx_type     req_free_index;
   logic             rsp_valid;
   slot_idx_type     rsp_slot_index;
   status_type       rsp_status;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int idle_pct    = 38;
   int items_sent  = 0;

   bitmap_slot_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_free_index (req_free_index),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   slot_grant_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_free_index (req_free_index),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** bitmap_slot_allocator: FAILED **");
         $finish;
      end
   end

   task automatic send_command(input logic cmd, input slot_idx_type idx);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            start          <= 1'b1;
            req_cmd        <= cmd;
            req_free_index <= idx;
            @(posedge clock);
            taken = !busy;
         end
      end
      items_sent++;
      if (items_sent < 600) idle_pct = 38;
      else if (items_sent < 1200) idle_pct = 86;
      else idle_pct = 0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_words(input logic [CSR_W-1:0] words);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= words;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int               n;
      int               alloc_pct;
      logic [CSR_W-1:0] words;
      start          = 1'b0;
      req_cmd        = CMD_ALLOC;
      req_free_index = '0;
      csr_valid      = 1'b0;
      csr_wdata      = CSR_WORDS_RESET;
      reset          = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset word count: grants from slot 0, release and re-grant
      send_command(CMD_ALLOC, '0);
      send_command(CMD_ALLOC, '1);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_FREE, 12'd1);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_FREE, 12'd1);
      send_command(CMD_FREE, 12'd1);
      send_command(CMD_FREE, 12'd4095);
      send_command(CMD_FREE, 12'd0);
      send_command(CMD_ALLOC, '1);

      write_words(7'd1);
      send_command(CMD_FREE, 12'd64);
      send_command(CMD_FREE, 12'd63);
      send_command(CMD_FREE, 12'd4095);
      send_command(CMD_ALLOC, '0);

      write_words(7'd0);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_FREE, 12'd0);

      write_words(7'd127);
      send_command(CMD_FREE, 12'd4095);
      send_command(CMD_ALLOC, '0);
      send_command(CMD_FREE, 12'd2048);

      write_words(7'd64);
      send_command(CMD_FREE, 12'd4032);
      send_command(CMD_ALLOC, '0);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 8)
            0:       words = 7'd1;
            1:       words = 7'd2;
            2:       words = 7'd64;
            3:       words = 7'd0;
            4:       words = 7'd127;
            5:       words = 7'($urandom_range(4, 1));
            6:       words = 7'($urandom_range(127, 0));
            default: words = 7'd1;
         endcase
         write_words(words);
         n         = (int'(words) > WORD_BITS) ? WORD_BITS : int'(words);
         alloc_pct = (n <= 4) ? 80 : 60;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < alloc_pct)
               send_command(CMD_ALLOC, slot_idx_type'($urandom));
            else if (n > 0 && $urandom_range(99) < 75)
               send_command(CMD_FREE, slot_idx_type'($urandom_range(n * WORD_BITS - 1, 0)));
            else
               send_command(CMD_FREE, slot_idx_type'($urandom));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** bitmap_slot_allocator: PASSED **");
      end else begin
         $display("** bitmap_slot_allocator: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bsa_pkg.sv
hw/rtl/bitmap_slot_allocator.sv
dv/slot_grant_checker.sv
dv/tb_bitmap_slot_allocator.sv
